>>> hw/rtl/flrc_pkg.sv
// ============================================================================
// flrc_pkg
// Shared types and codes of the failover lease and role controller.
// ============================================================================
package flrc_pkg;

    localparam int TIME_W     = 32;
    localparam int END_W      = TIME_W + 1;
    localparam int WIN_W      = 16;
    localparam int LEASE_W    = 32;
    localparam int ADDR_W     = 48;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int S_TDATA_W  = 120;
    localparam int S_TUSER_W  = 5;
    localparam int M_TDATA_W  = 96;

    typedef enum logic [2:0] {
        EV_QUERY       = 3'd0,
        EV_STARTUP     = 3'd1,
        EV_SWITCH      = 3'd2,
        EV_KEEPALIVE   = 3'd3,
        EV_PEER_UPDATE = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        KA_LOGIN  = 2'd0,
        KA_RENEW  = 2'd1,
        KA_LOGOUT = 2'd2,
        KA_ROLES  = 2'd3
    } ka_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_MASTER  = 2'd1,
        ST_NO_LEASE    = 2'd2,
        ST_LEASE_WRONG = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SAFE_WIN    = 2'd0,
        REG_DISCARD_WIN = 2'd1,
        REG_APPLY_WIN   = 2'd2,
        REG_HEARTBEAT   = 2'd3
    } reg_index_t;

    localparam logic [1:0] PEER_UNINIT = 2'd1;
    localparam logic [LEASE_W-1:0] LEASE_NONE = '0;
    localparam logic [LEASE_W-1:0] LEASE_FIRST = LEASE_W'(1);

    typedef struct packed {
        logic [WIN_W-1:0] safe_mode_window;
        logic [WIN_W-1:0] discard_block_window;
        logic [WIN_W-1:0] apply_block_window;
        logic [WIN_W-1:0] heartbeat_interval;
    } flrc_cfg_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [1:0]         keepalive_kind;
        logic [LEASE_W-1:0] lease_in;
        logic [ADDR_W-1:0]  peer_address;
        logic               peer_role_in;
        logic [1:0]         peer_status_in;
        logic               vip_is_local;
        logic [TIME_W-1:0]  now;
    } flrc_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [LEASE_W-1:0] lease_out;
        logic               self_is_master;
        logic               other_is_master;
        logic [1:0]         peer_status_out;
        logic [ADDR_W-1:0]  peer_address_out;
        logic               in_safe_mode;
        logic               in_discard_window;
        logic               in_apply_window;
        logic               lease_valid;
    } flrc_result_t;

endpackage

>>> hw/rtl/flrc_cfg_regs.sv
// ============================================================================
// flrc_cfg_regs
// APB register file holding the four window and interval settings.
// ============================================================================
module flrc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flrc_pkg::PADDR_W-1:0]  paddr,
    input  logic [flrc_pkg::PDATA_W-1:0]  pwdata,
    output logic [flrc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output flrc_pkg::flrc_cfg_t           cfg
);

    flrc_pkg::flrc_cfg_t  cfg_reg;
    logic                 wr_en;
    logic [1:0]           reg_sel;
    logic [flrc_pkg::WIN_W-1:0] wdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign wdata   = pwdata[flrc_pkg::WIN_W-1:0];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                flrc_pkg::REG_SAFE_WIN:    cfg_reg.safe_mode_window     <= wdata;
                flrc_pkg::REG_DISCARD_WIN: cfg_reg.discard_block_window <= wdata;
                flrc_pkg::REG_APPLY_WIN:   cfg_reg.apply_block_window   <= wdata;
                flrc_pkg::REG_HEARTBEAT:   cfg_reg.heartbeat_interval   <= wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            flrc_pkg::REG_SAFE_WIN:
                prdata = flrc_pkg::PDATA_W'(cfg_reg.safe_mode_window);
            flrc_pkg::REG_DISCARD_WIN:
                prdata = flrc_pkg::PDATA_W'(cfg_reg.discard_block_window);
            flrc_pkg::REG_APPLY_WIN:
                prdata = flrc_pkg::PDATA_W'(cfg_reg.apply_block_window);
            flrc_pkg::REG_HEARTBEAT:
                prdata = flrc_pkg::PDATA_W'(cfg_reg.heartbeat_interval);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/flrc_core.sv
// ============================================================================
// flrc_core
// Role, lease and window state with the per-event update and result logic.
// ============================================================================
module flrc_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  flrc_pkg::flrc_cfg_t    cfg,
    input  flrc_pkg::flrc_item_t   item,
    input  logic                   advance,
    output flrc_pkg::flrc_result_t result
);

    logic                           own_role_reg, own_role_next;
    logic                           other_role_reg, other_role_next;
    logic [1:0]                     other_status_reg, other_status_next;
    logic [flrc_pkg::ADDR_W-1:0]    other_address_reg, other_address_next;
    logic [flrc_pkg::LEASE_W-1:0]   current_lease_reg, current_lease_next;
    logic [flrc_pkg::LEASE_W-1:0]   lease_counter_reg, lease_counter_next;
    logic [flrc_pkg::END_W-1:0]     lease_expiry_reg, lease_expiry_next;
    logic [flrc_pkg::TIME_W-1:0]    startup_stamp_reg, startup_stamp_next;
    logic [flrc_pkg::END_W-1:0]     safe_end_reg, safe_end_next;
    logic [flrc_pkg::END_W-1:0]     discard_end_reg, discard_end_next;
    logic [flrc_pkg::END_W-1:0]     apply_end_reg, apply_end_next;

    logic [flrc_pkg::END_W-1:0]     now_ext;
    logic [flrc_pkg::END_W-1:0]     safe_sum, half_sum, discard_sum, apply_sum, lease_sum;
    logic [flrc_pkg::END_W-1:0]     startup_limit;
    logic [flrc_pkg::WIN_W-1:0]     half_window;
    logic                           after_startup;
    logic [flrc_pkg::LEASE_W-1:0]   counter_inc;
    logic                           safe_flag, discard_flag, apply_flag, lease_flag;
    logic [1:0]                     status;
    logic [flrc_pkg::LEASE_W-1:0]   lease_out;

    assign now_ext       = {1'b0, item.now};
    assign half_window   = cfg.safe_mode_window >> 1;
    assign safe_sum      = now_ext + flrc_pkg::END_W'(cfg.safe_mode_window);
    assign half_sum      = now_ext + flrc_pkg::END_W'(half_window);
    assign discard_sum   = now_ext + flrc_pkg::END_W'(cfg.discard_block_window);
    assign apply_sum     = now_ext + flrc_pkg::END_W'(cfg.apply_block_window);
    assign lease_sum     = now_ext + flrc_pkg::END_W'(cfg.heartbeat_interval);
    assign startup_limit = {1'b0, startup_stamp_reg}
                         + flrc_pkg::END_W'(cfg.safe_mode_window);
    assign after_startup = now_ext > startup_limit;
    assign counter_inc   = lease_counter_reg + flrc_pkg::LEASE_FIRST;

    // The window flags compare now against the ends after this event. Where an
    // end is rewritten as now plus a window, the flag reduces to window != 0,
    // which keeps the add off the compare path.
    always_comb begin
        own_role_next      = own_role_reg;
        other_role_next    = other_role_reg;
        other_status_next  = other_status_reg;
        other_address_next = other_address_reg;
        current_lease_next = current_lease_reg;
        lease_counter_next = lease_counter_reg;
        lease_expiry_next  = lease_expiry_reg;
        startup_stamp_next = startup_stamp_reg;
        safe_end_next      = safe_end_reg;
        discard_end_next   = discard_end_reg;
        apply_end_next     = apply_end_reg;
        status             = flrc_pkg::ST_OK;
        lease_out          = item.lease_in;
        safe_flag          = now_ext < safe_end_reg;
        discard_flag       = now_ext < discard_end_reg;
        apply_flag         = now_ext < apply_end_reg;
        lease_flag         = (current_lease_reg != flrc_pkg::LEASE_NONE)
                          && (lease_expiry_reg > now_ext);

        case (item.event_kind)
            flrc_pkg::EV_STARTUP: begin
                current_lease_next = flrc_pkg::LEASE_NONE;
                lease_expiry_next  = '0;
                startup_stamp_next = item.now;
                safe_end_next      = safe_sum;
                discard_end_next   = discard_sum;
                apply_end_next     = now_ext;
                other_role_next    = 1'b0;
                own_role_next      = item.vip_is_local;
                safe_flag          = cfg.safe_mode_window != '0;
                discard_flag       = cfg.discard_block_window != '0;
                apply_flag         = 1'b0;
                lease_flag         = 1'b0;
            end
            flrc_pkg::EV_SWITCH: begin
                current_lease_next = flrc_pkg::LEASE_NONE;
                lease_expiry_next  = '0;
                own_role_next      = ~own_role_reg;
                other_role_next    = own_role_reg;
                apply_end_next     = apply_sum;
                apply_flag         = cfg.apply_block_window != '0;
                lease_flag         = 1'b0;
                if (after_startup) begin
                    safe_end_next = half_sum;
                    safe_flag     = half_window != '0;
                end else begin
                    safe_end_next    = safe_sum;
                    discard_end_next = discard_sum;
                    safe_flag        = cfg.safe_mode_window != '0;
                    discard_flag     = cfg.discard_block_window != '0;
                end
            end
            flrc_pkg::EV_KEEPALIVE: begin
                if (!own_role_reg) begin
                    status = flrc_pkg::ST_NOT_MASTER;
                end else begin
                    other_status_next = item.peer_status_in;
                    other_role_next   = item.peer_role_in;
                    case (item.keepalive_kind)
                        flrc_pkg::KA_LOGIN: begin
                            other_address_next = item.peer_address;
                            // Lease ids skip zero, which marks no lease.
                            lease_counter_next = (counter_inc == flrc_pkg::LEASE_NONE)
                                               ? flrc_pkg::LEASE_FIRST : counter_inc;
                            current_lease_next = lease_counter_next;
                            lease_out          = lease_counter_next;
                            lease_expiry_next  = lease_sum;
                            lease_flag         = cfg.heartbeat_interval != '0;
                        end
                        flrc_pkg::KA_RENEW: begin
                            if (current_lease_reg == flrc_pkg::LEASE_NONE) begin
                                status = flrc_pkg::ST_NO_LEASE;
                            end else if (current_lease_reg != item.lease_in) begin
                                status = flrc_pkg::ST_LEASE_WRONG;
                            end else begin
                                lease_expiry_next = lease_sum;
                                lease_flag        = cfg.heartbeat_interval != '0;
                            end
                        end
                        flrc_pkg::KA_LOGOUT: begin
                            current_lease_next = flrc_pkg::LEASE_NONE;
                            other_status_next  = flrc_pkg::PEER_UNINIT;
                            lease_expiry_next  = '0;
                            lease_flag         = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            flrc_pkg::EV_PEER_UPDATE: begin
                other_address_next = item.peer_address;
                other_role_next    = item.peer_role_in;
                other_status_next  = item.peer_status_in;
            end
            default: ;
        endcase
    end

    always_comb begin
        result.status            = status;
        result.lease_out         = lease_out;
        result.self_is_master    = own_role_next;
        result.other_is_master   = other_role_next;
        result.peer_status_out   = other_status_next;
        result.peer_address_out  = other_address_next;
        result.in_safe_mode      = safe_flag;
        result.in_discard_window = discard_flag;
        result.in_apply_window   = apply_flag;
        result.lease_valid       = lease_flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_role_reg      <= 1'b0;
            other_role_reg    <= 1'b0;
            other_status_reg  <= '0;
            other_address_reg <= '0;
            current_lease_reg <= flrc_pkg::LEASE_NONE;
            lease_counter_reg <= flrc_pkg::LEASE_FIRST;
            lease_expiry_reg  <= '0;
            startup_stamp_reg <= '0;
            safe_end_reg      <= '0;
            discard_end_reg   <= '0;
            apply_end_reg     <= '0;
        end else if (advance) begin
            own_role_reg      <= own_role_next;
            other_role_reg    <= other_role_next;
            other_status_reg  <= other_status_next;
            other_address_reg <= other_address_next;
            current_lease_reg <= current_lease_next;
            lease_counter_reg <= lease_counter_next;
            lease_expiry_reg  <= lease_expiry_next;
            startup_stamp_reg <= startup_stamp_next;
            safe_end_reg      <= safe_end_next;
            discard_end_reg   <= discard_end_next;
            apply_end_reg     <= apply_end_next;
        end
    end

    a_counter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lease_counter_reg != flrc_pkg::LEASE_NONE)
        else $error("lease counter reached zero");

    a_switch_drops_lease: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.event_kind == flrc_pkg::EV_SWITCH)
        |=> (current_lease_reg == flrc_pkg::LEASE_NONE && lease_expiry_reg == '0))
        else $error("lease survived a role switch");

    a_slave_keepalive_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.event_kind == flrc_pkg::EV_KEEPALIVE && !own_role_reg)
        |=> ($stable(current_lease_reg) && $stable(other_address_reg)
             && $stable(other_status_reg) && $stable(other_role_reg)))
        else $error("keepalive on the slave changed state");

endmodule

>>> hw/rtl/failover_lease_role_controller.sv
// ============================================================================
// failover_lease_role_controller
// Master/slave failover controller: roles, peer lease and safe-mode windows.
// ============================================================================
//  channel | dir | ports                                 | carries
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser      | one event per transaction
//  m_      | out | m_tvalid m_tready m_tdata             | one result per event
//  apb     | in  | psel penable pwrite paddr pwdata      | four window and interval registers
//
//  One event is accepted per cycle while m_ is not stalled; its result is offered
//  on m_ after passing the input register, then the result register.
//  The whole state update and result are one combinational pass between them.
//  A stalled result holds the result register; the input register still
//  takes one more event, after which s_tready falls until m_tready returns.
//  Reset is synchronous on aresetn and clears the state and both valids.
module failover_lease_role_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lease_in[31:0], peer_address[79:32], peer_role_in[80],
    // peer_status_in[82:81], vip_is_local[83], now[115:84], zero pad
    input  logic [flrc_pkg::S_TDATA_W-1:0]  s_tdata,
    // event_kind[2:0], keepalive_kind[4:3]
    input  logic [flrc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], lease_out[33:2], self_is_master[34], other_is_master[35],
    // peer_status_out[37:36], peer_address_out[85:38], in_safe_mode[86],
    // in_discard_window[87], in_apply_window[88], lease_valid[89], zero pad
    output logic [flrc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [flrc_pkg::PADDR_W-1:0]    paddr,
    input  logic [flrc_pkg::PDATA_W-1:0]    pwdata,
    output logic [flrc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    flrc_pkg::flrc_cfg_t    cfg;
    flrc_pkg::flrc_item_t   s_item;
    flrc_pkg::flrc_item_t   in_item_reg;
    flrc_pkg::flrc_result_t core_result;
    flrc_pkg::flrc_result_t out_result_reg;
    logic                   in_valid_reg, in_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   s_take;
    logic                   advance;

    flrc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        s_item.event_kind     = s_tuser[2:0];
        s_item.keepalive_kind = s_tuser[4:3];
        s_item.lease_in       = s_tdata[31:0];
        s_item.peer_address   = s_tdata[79:32];
        s_item.peer_role_in   = s_tdata[80];
        s_item.peer_status_in = s_tdata[82:81];
        s_item.vip_is_local   = s_tdata[83];
        s_item.now            = s_tdata[115:84];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    flrc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .advance (advance),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_result_reg.lease_valid,
                       out_result_reg.in_apply_window,
                       out_result_reg.in_discard_window,
                       out_result_reg.in_safe_mode,
                       out_result_reg.peer_address_out,
                       out_result_reg.peer_status_out,
                       out_result_reg.other_is_master,
                       out_result_reg.self_is_master,
                       out_result_reg.lease_out,
                       out_result_reg.status};

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || !in_valid_reg) |-> s_tready)
        else $error("input stalled with room in the pipeline");

    a_result_follows_event: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed event produced no result");

endmodule

>>> tb/failover_lease_role_controller_test.sv
`timescale 1ns / 1ps
// ============================================================================
// failover_lease_role_controller_test
// Streams time-stamped failover events through the controller. Each event is
// predicted by a behavioral copy of the role, lease and safe-window logic,
// and every result is compared field by field. The window registers are
// reprogrammed over APB between phases. Both stream sides idle and stall at
// random, and the result side is held off in three phases to back up the input.
// ============================================================================
module failover_lease_role_controller_test;

    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_LIMIT   = 40;
    localparam int PHASE_EVENTS  = 250;

    typedef struct packed {
        logic                         own_master;
        logic                         peer_master;
        logic [1:0]                   peer_state;
        logic [flrc_pkg::ADDR_W-1:0]  peer_address;
        logic [flrc_pkg::LEASE_W-1:0] lease;
        logic [flrc_pkg::LEASE_W-1:0] lease_counter;
        logic [flrc_pkg::END_W-1:0]   lease_expiry;
        logic [flrc_pkg::TIME_W-1:0]  startup_stamp;
        logic [flrc_pkg::END_W-1:0]   safe_end;
        logic [flrc_pkg::END_W-1:0]   discard_end;
        logic [flrc_pkg::END_W-1:0]   apply_end;
    } ctrl_state_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [flrc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [flrc_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [flrc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [flrc_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [flrc_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [flrc_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    flrc_pkg::flrc_item_t   pending_events[$];
    flrc_pkg::flrc_result_t expected_results[$];

    // live_state follows accepted events; plan_state follows generated ones so
    // that the stimulus can present the lease id that is currently held.
    ctrl_state_t          live_state;
    ctrl_state_t          plan_state;
    flrc_pkg::flrc_cfg_t  window_cfg = '0;

    logic [flrc_pkg::TIME_W-1:0] wall_clock = '0;
    int  win_span         = 16;
    bit  calm_phase       = 1'b0;
    int  holds_asked      = 0;
    int  holds_done       = 0;
    int  gap_left         = 0;
    int  stall_left       = 0;
    int  failures         = 0;
    int  events_queued    = 0;
    int  events_accepted  = 0;
    int  results_checked  = 0;
    int  settings_applied = 0;
    int  master_keepalives = 0;
    int  refused_renews   = 0;

    flrc_pkg::flrc_item_t   driven_event;
    flrc_pkg::flrc_item_t   seen_event;
    flrc_pkg::flrc_result_t predicted;
    flrc_pkg::flrc_result_t got_result;
    flrc_pkg::flrc_result_t want_result;

    failover_lease_role_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic ctrl_state_t reset_state();
        ctrl_state_t s;
        s = '0;
        s.lease_counter = flrc_pkg::LEASE_FIRST;
        return s;
    endfunction

    // Applies one event to a controller state and returns its result.
    task automatic advance_controller(inout ctrl_state_t s, input flrc_pkg::flrc_cfg_t c,
                                      input flrc_pkg::flrc_item_t ev,
                                      output flrc_pkg::flrc_result_t r);
        logic [flrc_pkg::END_W-1:0] now_x;
        now_x = {1'b0, ev.now};
        r = '0;
        r.status = flrc_pkg::ST_OK;
        r.lease_out = ev.lease_in;
        case (ev.event_kind)
            flrc_pkg::EV_STARTUP: begin
                s.lease         = flrc_pkg::LEASE_NONE;
                s.lease_expiry  = '0;
                s.startup_stamp = ev.now;
                s.safe_end      = now_x + c.safe_mode_window;
                s.discard_end   = now_x + c.discard_block_window;
                s.apply_end     = now_x;
                s.peer_master   = 1'b0;
                s.own_master    = ev.vip_is_local;
            end
            flrc_pkg::EV_SWITCH: begin
                s.lease        = flrc_pkg::LEASE_NONE;
                s.lease_expiry = '0;
                s.own_master   = ~s.own_master;
                s.peer_master  = ~s.own_master;
                s.apply_end    = now_x + c.apply_block_window;
                // A switch after the startup window gets only half the safe window.
                if (now_x > {1'b0, s.startup_stamp} + c.safe_mode_window) begin
                    s.safe_end = now_x + (c.safe_mode_window >> 1);
                end else begin
                    s.safe_end    = now_x + c.safe_mode_window;
                    s.discard_end = now_x + c.discard_block_window;
                end
            end
            flrc_pkg::EV_KEEPALIVE: begin
                if (!s.own_master) begin
                    r.status = flrc_pkg::ST_NOT_MASTER;
                end else begin
                    s.peer_state  = ev.peer_status_in;
                    s.peer_master = ev.peer_role_in;
                    case (ev.keepalive_kind)
                        flrc_pkg::KA_LOGIN: begin
                            s.peer_address  = ev.peer_address;
                            s.lease_counter = s.lease_counter + 1'b1;
                            if (s.lease_counter == flrc_pkg::LEASE_NONE) begin
                                s.lease_counter = flrc_pkg::LEASE_FIRST;
                            end
                            s.lease        = s.lease_counter;
                            r.lease_out    = s.lease;
                            s.lease_expiry = now_x + c.heartbeat_interval;
                        end
                        flrc_pkg::KA_RENEW: begin
                            if (s.lease == flrc_pkg::LEASE_NONE) begin
                                r.status = flrc_pkg::ST_NO_LEASE;
                            end else if (s.lease != ev.lease_in) begin
                                r.status = flrc_pkg::ST_LEASE_WRONG;
                            end else begin
                                s.lease_expiry = now_x + c.heartbeat_interval;
                            end
                        end
                        flrc_pkg::KA_LOGOUT: begin
                            s.lease        = flrc_pkg::LEASE_NONE;
                            s.peer_state   = flrc_pkg::PEER_UNINIT;
                            s.lease_expiry = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            flrc_pkg::EV_PEER_UPDATE: begin
                s.peer_address = ev.peer_address;
                s.peer_master  = ev.peer_role_in;
                s.peer_state   = ev.peer_status_in;
            end
            default: begin
            end
        endcase
        r.self_is_master    = s.own_master;
        r.other_is_master   = s.peer_master;
        r.peer_status_out   = s.peer_state;
        r.peer_address_out  = s.peer_address;
        r.in_safe_mode      = now_x < s.safe_end;
        r.in_discard_window = now_x < s.discard_end;
        r.in_apply_window   = now_x < s.apply_end;
        r.lease_valid       = (s.lease != flrc_pkg::LEASE_NONE) && (s.lease_expiry > now_x);
    endtask

    task automatic report_failure(input string what);
        if (failures < PRINT_LIMIT) begin
            $display("mismatch at %0t ns: %s", $realtime, what);
        end
        failures++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_failure($sformatf("result %0d %s: got %0h, expected %0h",
                                     results_checked, name, got, want));
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Time mostly creeps forward so that window edges get crossed, with
    // occasional jumps anywhere and close to the top of the range.
    function automatic logic [flrc_pkg::TIME_W-1:0] next_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            wall_clock = wall_clock + $urandom_range(0, 12);
        end else if (r < 80) begin
            wall_clock = wall_clock + $urandom_range(0, win_span);
        end else if (r < 90) begin
            wall_clock = wall_clock + $urandom_range(0, 140000);
        end else if (r < 95) begin
            wall_clock = $urandom;
        end else begin
            wall_clock = 32'hFFFF_FFFF - $urandom_range(0, 70000);
        end
        return wall_clock;
    endfunction

    function automatic flrc_pkg::flrc_item_t rand_event(input logic [2:0] kind,
                                                        input logic [1:0] ka);
        flrc_pkg::flrc_item_t ev;
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        ev.event_kind     = kind;
        ev.keepalive_kind = ka;
        ev.lease_in       = $urandom;
        ev.peer_address   = wide[flrc_pkg::ADDR_W-1:0];
        ev.peer_role_in   = 1'($urandom_range(0, 1));
        ev.peer_status_in = 2'($urandom_range(0, 3));
        ev.vip_is_local   = 1'($urandom_range(0, 1));
        ev.now            = next_now();
        return ev;
    endfunction

    task automatic queue_event(input flrc_pkg::flrc_item_t ev);
        flrc_pkg::flrc_result_t scratch;
        advance_controller(plan_state, window_cfg, ev, scratch);
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic queue_kind(input logic [2:0] kind, input logic [1:0] ka,
                              input logic [flrc_pkg::TIME_W-1:0] at,
                              input logic [flrc_pkg::LEASE_W-1:0] lease_arg,
                              input logic vip);
        flrc_pkg::flrc_item_t ev;
        ev = rand_event(kind, ka);
        ev.now          = at;
        ev.lease_in     = lease_arg;
        ev.vip_is_local = vip;
        queue_event(ev);
    endtask

    task automatic write_register(input flrc_pkg::reg_index_t idx,
                                  input logic [flrc_pkg::WIN_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= flrc_pkg::PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            flrc_pkg::REG_SAFE_WIN:    window_cfg.safe_mode_window     = value;
            flrc_pkg::REG_DISCARD_WIN: window_cfg.discard_block_window = value;
            flrc_pkg::REG_APPLY_WIN:   window_cfg.apply_block_window   = value;
            flrc_pkg::REG_HEARTBEAT:   window_cfg.heartbeat_interval   = value;
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(input logic [flrc_pkg::WIN_W-1:0] safe_win,
                                  input logic [flrc_pkg::WIN_W-1:0] discard_win,
                                  input logic [flrc_pkg::WIN_W-1:0] apply_win,
                                  input logic [flrc_pkg::WIN_W-1:0] heartbeat);
        write_register(flrc_pkg::REG_SAFE_WIN, safe_win);
        write_register(flrc_pkg::REG_DISCARD_WIN, discard_win);
        write_register(flrc_pkg::REG_APPLY_WIN, apply_win);
        write_register(flrc_pkg::REG_HEARTBEAT, heartbeat);
        win_span = 2 * (int'(safe_win) + int'(discard_win) + int'(apply_win)
                   + int'(heartbeat)) / 4 + 4;
        settings_applied++;
    endtask

    // Waits until every queued event has produced its result, then lets the
    // pipeline settle. Polling on the falling edge keeps it clear of the
    // driver and monitors.
    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_directed();
        flrc_pkg::flrc_item_t ev;
        queue_kind(flrc_pkg::EV_QUERY, flrc_pkg::KA_LOGIN, 32'd0, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGIN, 32'd50, 32'd0, 1'b1);
        ev = rand_event(flrc_pkg::EV_PEER_UPDATE, flrc_pkg::KA_ROLES);
        ev.peer_address   = '1;
        ev.peer_role_in   = 1'b1;
        ev.peer_status_in = 2'd3;
        ev.now            = 32'd60;
        queue_event(ev);
        queue_kind(flrc_pkg::EV_STARTUP, flrc_pkg::KA_LOGIN, 32'd100, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW, 32'd101, plan_state.lease, 1'b0);
        // Inside the startup window: full safe window, discard window restarts.
        queue_kind(flrc_pkg::EV_SWITCH, flrc_pkg::KA_LOGIN, 32'd105, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGIN, 32'd106, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW, 32'd110, plan_state.lease, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW, 32'd111, 32'hFFFF_FFFF, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_ROLES, 32'd112, 32'd0, 1'b1);
        queue_kind(flrc_pkg::EV_QUERY, flrc_pkg::KA_RENEW, 32'd117, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_QUERY, flrc_pkg::KA_RENEW, 32'd118, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGOUT, 32'd119, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW, 32'd120, 32'd0, 1'b0);
        // Exactly at the end of the startup window, then one time unit past it.
        queue_kind(flrc_pkg::EV_SWITCH, flrc_pkg::KA_LOGIN, 32'd110, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_SWITCH, flrc_pkg::KA_LOGIN, 32'd111, 32'd0, 1'b0);
        // Sums at the top of the time range must carry into the extra bit.
        queue_kind(flrc_pkg::EV_STARTUP, flrc_pkg::KA_LOGIN, 32'hFFFF_FFFF, 32'd0, 1'b1);
        queue_kind(flrc_pkg::EV_QUERY, flrc_pkg::KA_ROLES, 32'hFFFF_FFFF, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGIN, 32'hFFFF_FFFF, 32'd0, 1'b0);
        queue_kind(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW, 32'hFFFF_FFFF,
                   plan_state.lease, 1'b0);
        for (int k = 5; k < 8; k++) begin
            queue_kind(3'(k), flrc_pkg::KA_LOGOUT, 32'hFFFF_FFF0, 32'hA5A5_5A5A, 1'b1);
        end
        ev = rand_event(flrc_pkg::EV_PEER_UPDATE, flrc_pkg::KA_LOGIN);
        ev.peer_address = '0;
        ev.now          = 32'd0;
        queue_event(ev);
        queue_kind(flrc_pkg::EV_QUERY, flrc_pkg::KA_LOGIN, 32'd0, 32'd0, 1'b0);
        wall_clock = 32'd200;
    endtask

    // A well-formed exchange: take the master role, log the peer in, renew
    // with the held id (and now and then a wrong one), and maybe log out or
    // switch away.
    task automatic queue_session();
        flrc_pkg::flrc_item_t ev;
        int steps;
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            ev = rand_event(flrc_pkg::EV_STARTUP, 2'($urandom_range(0, 3)));
            ev.vip_is_local = ($urandom_range(0, 9) != 0);
            queue_event(ev);
        end else if (r < 85) begin
            queue_event(rand_event(flrc_pkg::EV_SWITCH, 2'($urandom_range(0, 3))));
        end
        queue_event(rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGIN));
        steps = $urandom_range(1, 8);
        repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                ev = rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW);
                ev.lease_in = plan_state.lease;
            end else if (r < 60) begin
                ev = rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW);
                ev.lease_in = plan_state.lease ^ (32'd1 << $urandom_range(0, 31));
            end else if (r < 70) begin
                ev = rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_ROLES);
            end else if (r < 82) begin
                ev = rand_event(flrc_pkg::EV_QUERY, 2'($urandom_range(0, 3)));
            end else if (r < 92) begin
                ev = rand_event(flrc_pkg::EV_PEER_UPDATE, 2'($urandom_range(0, 3)));
            end else begin
                ev = rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGIN);
            end
            queue_event(ev);
        end
        if ($urandom_range(0, 99) < 40) begin
            queue_event(rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_LOGOUT));
            if ($urandom_range(0, 2) == 0) begin
                queue_event(rand_event(flrc_pkg::EV_KEEPALIVE, flrc_pkg::KA_RENEW));
            end
        end
        if ($urandom_range(0, 99) < 20) begin
            queue_event(rand_event(flrc_pkg::EV_SWITCH, 2'($urandom_range(0, 3))));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = events_queued + count;
        while (events_queued < target) begin
            if ($urandom_range(0, 99) < 75) begin
                queue_session();
            end else begin
                queue_event(rand_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))));
            end
        end
    endtask

    function automatic logic [flrc_pkg::WIN_W-1:0] small_window();
        return flrc_pkg::WIN_W'($urandom_range(0, 40));
    endfunction

    // Event driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                driven_event = pending_events.pop_front();
                s_tdata  <= {4'b0, driven_event.now, driven_event.vip_is_local,
                             driven_event.peer_status_in, driven_event.peer_role_in,
                             driven_event.peer_address, driven_event.lease_in};
                s_tuser  <= {driven_event.keepalive_kind, driven_event.event_kind};
                s_tvalid <= 1'b1;
                gap_left = calm_phase ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = calm_phase ? 0 : pick_gap();
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Every accepted event is predicted at the edge that takes it.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            seen_event.lease_in       = s_tdata[31:0];
            seen_event.peer_address   = s_tdata[79:32];
            seen_event.peer_role_in   = s_tdata[80];
            seen_event.peer_status_in = s_tdata[82:81];
            seen_event.vip_is_local   = s_tdata[83];
            seen_event.now            = s_tdata[115:84];
            seen_event.event_kind     = s_tuser[2:0];
            seen_event.keepalive_kind = s_tuser[4:3];
            advance_controller(live_state, window_cfg, seen_event, predicted);
            expected_results.push_back(predicted);
            events_accepted++;
            if (seen_event.event_kind == flrc_pkg::EV_KEEPALIVE
                && predicted.status != flrc_pkg::ST_NOT_MASTER) begin
                master_keepalives++;
            end
            if (predicted.status == flrc_pkg::ST_NO_LEASE
                || predicted.status == flrc_pkg::ST_LEASE_WRONG) begin
                refused_renews++;
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.status            = m_tdata[1:0];
            got_result.lease_out         = m_tdata[33:2];
            got_result.self_is_master    = m_tdata[34];
            got_result.other_is_master   = m_tdata[35];
            got_result.peer_status_out   = m_tdata[37:36];
            got_result.peer_address_out  = m_tdata[85:38];
            got_result.in_safe_mode      = m_tdata[86];
            got_result.in_discard_window = m_tdata[87];
            got_result.in_apply_window   = m_tdata[88];
            got_result.lease_valid       = m_tdata[89];
            if (expected_results.size() == 0) begin
                report_failure("result with no event waiting for it");
            end else begin
                want_result = expected_results.pop_front();
                check_field("status", got_result.status, want_result.status);
                check_field("lease_out", got_result.lease_out, want_result.lease_out);
                check_field("self_is_master", got_result.self_is_master,
                            want_result.self_is_master);
                check_field("other_is_master", got_result.other_is_master,
                            want_result.other_is_master);
                check_field("peer_status_out", got_result.peer_status_out,
                            want_result.peer_status_out);
                check_field("peer_address_out", got_result.peer_address_out,
                            want_result.peer_address_out);
                check_field("in_safe_mode", got_result.in_safe_mode, want_result.in_safe_mode);
                check_field("in_discard_window", got_result.in_discard_window,
                            want_result.in_discard_window);
                check_field("in_apply_window", got_result.in_apply_window,
                            want_result.in_apply_window);
                check_field("lease_valid", got_result.lease_valid, want_result.lease_valid);
                results_checked++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        live_state = reset_state();
        plan_state = reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        apply_settings(16'd10, 16'd20, 16'd5, 16'd8);
        run_directed();
        wait_idle();

        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(PHASE_EVENTS);
        wait_idle();

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(PHASE_EVENTS);
        wait_idle();

        // Back-to-back events while the result side is held off.
        apply_settings(small_window(), small_window(), small_window(), small_window());
        calm_phase = 1'b1;
        holds_asked++;
        run_random(PHASE_EVENTS);
        wait_idle();
        calm_phase = 1'b0;

        repeat (2) begin
            apply_settings(small_window(), small_window(), small_window(), small_window());
            holds_asked++;
            run_random(PHASE_EVENTS);
            wait_idle();
        end

        apply_settings(16'hFFFF, 16'd0, flrc_pkg::WIN_W'($urandom),
                       flrc_pkg::WIN_W'($urandom));
        run_random(PHASE_EVENTS / 2);
        wait_idle();

        apply_settings(flrc_pkg::WIN_W'($urandom), flrc_pkg::WIN_W'($urandom),
                       flrc_pkg::WIN_W'($urandom), small_window());
        run_random(PHASE_EVENTS / 2);
        wait_idle();

        if (expected_results.size() > 0) begin
            report_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("run covered %0d events and %0d checked results over %0d window settings",
                 events_accepted, results_checked, settings_applied);
        $display("keepalives taken as master: %0d, renews refused: %0d, failures: %0d",
                 master_keepalives, refused_renews, failures);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
